@@ hdl/distinct_duplicate_counter_assert.svh @@
// Assertion macros shared by the checker of the duplicate counter.
// Depends on nothing; include by bare file name.
`ifndef DISTINCT_DUPLICATE_COUNTER_ASSERT_SVH
`define DISTINCT_DUPLICATE_COUNTER_ASSERT_SVH

// Same-cycle implication under clock and synchronous reset.
`define DDC_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication under clock and synchronous reset.
`define DDC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/ddc_pkg.sv @@
// Shared constants and types of the duplicate counter.
// Used by the compare cell, the top level and the checker.
package ddc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  // Largest count the block can report.
  localparam int CNT_LIMIT = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic take;   // an item is transferred this cycle
    logic miss;   // no stored entry holds the item's value
    logic clear;  // end of sequence: drop the whole table
  } ddc_ctl_t;

endpackage

@@ hdl/ddc_cell.sv @@
// One table entry: a stored value, its valid bit and its repeat mark.
// Depends on ddc_pkg; chained through the valid bit to its neighbor.
module ddc_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  ddc_pkg::ddc_ctl_t            ctl,
  input  logic [ddc_pkg::VALUE_W-1:0]  value,
  input  logic                         prev_valid,
  output logic                         valid,
  output logic                         hit,
  output logic                         fresh
);
  import ddc_pkg::*;

  logic [VALUE_W-1:0] stored;
  logic               mark;
  logic               load;

  assign hit   = valid && (stored == value);
  assign fresh = hit && !mark;
  // First free cell in the chain takes a value nobody holds.
  assign load  = ctl.take && ctl.miss && prev_valid && !valid;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
      mark  <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      mark  <= 1'b0;
    end else if (ctl.take && hit) begin
      mark <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stored <= value;
    end
  end

endmodule

@@ hdl/distinct_duplicate_counter.sv @@
// Counts distinct values that occur twice or more in a stream of 32-bit items.
// Input channel s_*: s_tdata carries the value, s_tlast marks the sequence end.
// Output channel m_*: one transfer per sequence, sent after the tlast item.
// Each item is compared at once against a row of
// TABLE_DEPTH cells, each holding one distinct value and its repeat mark;
// a value nobody holds drops into the first free cell of the chain.
// Throughput is one item per cycle while the output register is free.
// m_tvalid is registered and rises in the cycle after the tlast transfer.
// A new distinct value that finds every cell in use is not stored and sets
// the overflow bit of the result.
// After the tlast item the table, count and overflow clear for the next run.
// While a result waits on m_tready low, s_tready stays low.
// Reset (rst, synchronous) empties the table and drops any pending result.
module distinct_duplicate_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [6:0] duplicate_count, [7] overflow
);
  import ddc_pkg::*;

  ddc_ctl_t                 ctl;
  logic [TABLE_DEPTH-1:0]   valid;
  logic [TABLE_DEPTH-1:0]   hit;
  logic [TABLE_DEPTH-1:0]   fresh;
  logic [TABLE_DEPTH:0]     chain;
  logic                     any_hit;
  logic                     any_fresh;
  logic [COUNT_W-1:0]       running_count;
  logic [COUNT_W-1:0]       count_next;
  logic                     overflow_seen;
  logic                     overflow_next;
  logic [COUNT_W-1:0]       duplicate_count;
  logic                     overflow;

  assign s_tready  = !m_tvalid || m_tready;
  assign any_hit   = |hit;
  assign any_fresh = |fresh;

  assign ctl.take  = s_tvalid && s_tready;
  assign ctl.miss  = !any_hit;
  assign ctl.clear = ctl.take && s_tlast;

  assign chain[0] = 1'b1;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ddc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .value      (s_tdata[VALUE_W-1:0]),
      .prev_valid (chain[i]),
      .valid      (valid[i]),
      .hit        (hit[i]),
      .fresh      (fresh[i])
    );
    assign chain[i+1] = valid[i];
  end

  always_comb begin
    count_next    = running_count;
    overflow_next = overflow_seen;
    if (any_fresh && running_count != COUNT_MAX) begin
      count_next = running_count + 1'b1;
    end
    // Table full: the last cell of the chain is in use.
    if (!any_hit && chain[TABLE_DEPTH]) begin
      overflow_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
      overflow_seen <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (ctl.clear) begin
        running_count <= '0;
        overflow_seen <= 1'b0;
      end else if (ctl.take) begin
        running_count <= count_next;
        overflow_seen <= overflow_next;
      end
      if (ctl.clear) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold the result until the transfer completes.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      duplicate_count <= count_next;
      overflow        <= overflow_next;
    end
  end

  assign m_tdata = {overflow, duplicate_count};

endmodule

@@ hdl/ddc_checker.sv @@
// Port-level checker of the duplicate counter, bound to the top level.
// Depends on ddc_pkg and distinct_duplicate_counter_assert.svh.
`include "distinct_duplicate_counter_assert.svh"

module ddc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);
  import ddc_pkg::*;

  logic end_seq;
  assign end_seq = s_tvalid && s_tready && s_tlast;

  `DDC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `DDC_ASSERT_NEXT(a_last_gives_result, clk, rst, end_seq, m_tvalid, "no result after tlast transfer")
  `DDC_ASSERT_NOW(a_stall_blocks_input, clk, rst, m_tvalid && !m_tready, !s_tready, "input taken while result stalled")
  `DDC_ASSERT_NOW(a_count_range, clk, rst, m_tvalid, m_tdata[6:0] <= 7'(CNT_LIMIT), "count above table depth")

endmodule

bind distinct_duplicate_counter ddc_checker u_ddc_checker (.*);
